// ----- sv/vsfm_pkg.sv -----
// ----------------------------------------------------------------------------
// vsfm_pkg
// Shared codes, tables and controller/datapath types for the voxel mesher.
// ----------------------------------------------------------------------------
package vsfm_pkg;

  localparam logic [2:0] OP_WRITE_BOTH = 3'd0;
  localparam logic [2:0] OP_WRITE_ID   = 3'd1;
  localparam logic [2:0] OP_WRITE_META = 3'd2;
  localparam logic [2:0] OP_READ       = 3'd3;
  localparam logic [2:0] OP_MESH_START = 3'd4;
  localparam logic [2:0] OP_MESH_CELL  = 3'd5;

  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [2:0] FACE_LAST = 3'd5;

  // corner offset bits: [2] x, [1] y, [0] z
  localparam logic [2:0] CORNER_POS [8] = '{
    3'b111, 3'b011, 3'b001, 3'b101, 3'b010, 3'b110, 3'b100, 3'b000
  };

  localparam logic [2:0] FACE_CORNERS [6][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd5, 3'd0, 3'd3, 3'd6},
    '{3'd4, 3'd5, 3'd6, 3'd7}, '{3'd1, 3'd4, 3'd7, 3'd2},
    '{3'd5, 3'd4, 3'd1, 3'd0}, '{3'd3, 3'd2, 3'd7, 3'd6}
  };

  localparam logic signed [1:0] STEP_X [6] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [1:0] STEP_Y [6] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_Z [6] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CTR_RD,
    S_CTR_CHK,
    S_NB_RD,
    S_NB_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic rd_center;
    logic rd_nb;
    logic wr_en;
    logic vcnt_clr;
    logic mask_cap;
    logic face_clr;
    logic face_inc;
    logic corner_inc;
    logic load_rd;
    logic load_vtx;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       in_fire;
    logic [2:0] opcode;
    logic       ctr_id_nz;
    logic       face_hit;
    logic       face_last;
    logic       corner_last;
    logic       rest_empty;
    logic       out_free;
  } dp_sts_t;

endpackage

// ----- sv/vsfm_in_if.sv -----
// ----------------------------------------------------------------------------
// vsfm_in_if
// Command channel: opcode, cell coordinate and write data.
// ----------------------------------------------------------------------------
interface vsfm_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [6:0] pos_x;
  logic signed [6:0] pos_y;
  logic signed [6:0] pos_z;
  logic [15:0]       new_id;
  logic [15:0]       new_meta;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, new_id, new_meta,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_z, new_id, new_meta,
                output ready);
endinterface

// ----- sv/vsfm_out_if.sv -----
// ----------------------------------------------------------------------------
// vsfm_out_if
// Result channel: read data or one mesh vertex per beat.
// ----------------------------------------------------------------------------
interface vsfm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_id;
  logic [15:0] read_meta;
  logic [5:0]  vert_x;
  logic [5:0]  vert_y;
  logic [5:0]  vert_z;
  logic        tex_u;
  logic        tex_v;
  logic [2:0]  face_dir;
  logic [19:0] vertex_number;
  logic        last;

  modport source (output valid, read_id, read_meta, vert_x, vert_y, vert_z, tex_u,
                  tex_v, face_dir, vertex_number, last, input ready);
  modport sink (input valid, read_id, read_meta, vert_x, vert_y, vert_z, tex_u,
                tex_v, face_dir, vertex_number, last, output ready);
endinterface

// ----- sv/voxel_store_face_mesher.sv -----
// ----------------------------------------------------------------------------
// voxel_store_face_mesher
// Voxel store with per-cell face culling mesher.
//
//   channel  dir  beat contents
//   in_ch    in   opcode, pos_x/y/z, new_id, new_meta
//   out_ch   out  read_id/meta or one vertex, last
//   cfg_*    in   size_x/y/z write (no handshake)
//
// Every command reads the center cell first. A mesh cell on a non-empty cell
// then reads its six neighbors one at a time and emits four vertices per
// visible face, passing over hidden faces, since one memory read port serves
// the center and six neighbors.
// After reset a clearing pass writes MAX_DIM**3 words, one per cycle, and
// takes no commands until it ends. A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module voxel_store_face_mesher import vsfm_pkg::*; #(
  parameter int MAX_DIM      = 32,
  parameter int FLOOR_LAYERS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [5:0] cfg_data,
  vsfm_in_if.sink    in_ch,
  vsfm_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vsfm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  vsfm_dp #(
    .MAX_DIM      (MAX_DIM),
    .FLOOR_LAYERS (FLOOR_LAYERS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ----- sv/vsfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// vsfm_ctrl
// Sequencer: store clear, command decode, neighbor scan and vertex emission.
// ----------------------------------------------------------------------------
module vsfm_ctrl import vsfm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) state_nxt = S_CTR_RD;
      end
      S_CTR_RD: begin
        cmd.rd_center = 1'b1;
        state_nxt     = S_CTR_CHK;
      end
      S_CTR_CHK: begin
        state_nxt = S_IDLE;
        unique case (sts.opcode)
          OP_WRITE_BOTH, OP_WRITE_ID, OP_WRITE_META: cmd.wr_en = 1'b1;
          OP_READ: begin
            if (sts.out_free) begin
              cmd.load_rd = 1'b1;
            end else begin
              state_nxt = S_CTR_CHK;
            end
          end
          OP_MESH_START: cmd.vcnt_clr = 1'b1;
          OP_MESH_CELL: begin
            if (sts.ctr_id_nz) begin
              cmd.face_clr = 1'b1;
              state_nxt    = S_NB_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_NB_RD: begin
        cmd.rd_nb = 1'b1;
        state_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd.mask_cap = 1'b1;
        if (sts.face_last) begin
          cmd.face_clr = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.face_inc = 1'b1;
          state_nxt    = S_NB_RD;
        end
      end
      S_EMIT: begin
        if (!sts.face_hit) begin
          if (sts.face_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.face_inc = 1'b1;
          end
        end else if (sts.out_free) begin
          cmd.load_vtx   = 1'b1;
          cmd.corner_inc = 1'b1;
          if (sts.corner_last) begin
            if (sts.face_last || sts.rest_empty) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.face_inc = 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ----- sv/vsfm_dp.sv -----
// ----------------------------------------------------------------------------
// vsfm_dp
// Datapath: size registers, voxel memory, scan registers, vertex counter
// and the result register.
// ----------------------------------------------------------------------------
module vsfm_dp import vsfm_pkg::*; #(
  parameter int MAX_DIM      = 32,
  parameter int FLOOR_LAYERS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [5:0]       cfg_data,
  vsfm_in_if.sink          in_ch,
  vsfm_out_if.source       out_ch,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_DIM);
  localparam logic [AW-1:0] STRIDE_Z = AW'(MAX_DIM * MAX_DIM);
  localparam logic [CW-1:0] CLR_MAX  = CW'(MAX_DIM - 1);
  localparam logic [6:0]    DIM7     = 7'(MAX_DIM);

  logic [5:0] size_x_r, size_y_r, size_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 6'd16;
      size_y_r <= 6'd16;
      size_z_r <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [6:0] eff_size(input logic [5:0] s);
    return ({1'b0, s} > DIM7) ? DIM7 : {1'b0, s};
  endfunction

  // command registers
  logic [2:0]        op_r;
  logic signed [6:0] px_r, py_r, pz_r;
  logic [15:0]       nid_r, nmeta_r;
  logic              in_fire;

  assign in_ch.ready = cmd.in_ready;
  assign in_fire     = in_ch.valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.opcode;
      px_r    <= in_ch.pos_x;
      py_r    <= in_ch.pos_y;
      pz_r    <= in_ch.pos_z;
      nid_r   <= in_ch.new_id;
      nmeta_r <= in_ch.new_meta;
    end
  end

  // scan counters
  logic [2:0] face_r;
  logic [1:0] corner_r;
  logic [5:0] mask_r;

  // read address: center or neighbor of the current face
  logic signed [1:0] dx, dy, dz;
  logic signed [7:0] qx, qy, qz;
  logic              q_in;
  logic [AW-1:0]     q_addr;

  always_comb begin
    dx = cmd.rd_nb ? STEP_X[face_r] : 2'sd0;
    dy = cmd.rd_nb ? STEP_Y[face_r] : 2'sd0;
    dz = cmd.rd_nb ? STEP_Z[face_r] : 2'sd0;
    qx = {px_r[6], px_r} + {{6{dx[1]}}, dx};
    qy = {py_r[6], py_r} + {{6{dy[1]}}, dy};
    qz = {pz_r[6], pz_r} + {{6{dz[1]}}, dz};
    q_in = !qx[7] && (qx[6:0] < eff_size(size_x_r)) &&
           !qy[7] && (qy[6:0] < eff_size(size_y_r)) &&
           !qz[7] && (qz[6:0] < eff_size(size_z_r));
    q_addr = AW'(qx[CW-1:0]) + AW'(qy[CW-1:0]) * STRIDE_Y + AW'(qz[CW-1:0]) * STRIDE_Z;
  end

  // clearing sweep
  logic [CW-1:0] clr_x_r, clr_y_r, clr_z_r;
  logic          clr_done_r;
  logic [AW-1:0] clr_addr;
  logic          clr_floor;

  assign clr_addr  = AW'(clr_x_r) + AW'(clr_y_r) * STRIDE_Y + AW'(clr_z_r) * STRIDE_Z;
  assign clr_floor = 7'(clr_y_r) < 7'(FLOOR_LAYERS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_x_r    <= '0;
      clr_y_r    <= '0;
      clr_z_r    <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_x_r <= (clr_x_r == CLR_MAX) ? '0 : clr_x_r + 1'b1;
      if (clr_x_r == CLR_MAX) begin
        clr_y_r <= (clr_y_r == CLR_MAX) ? '0 : clr_y_r + 1'b1;
        if (clr_y_r == CLR_MAX) begin
          clr_z_r <= (clr_z_r == CLR_MAX) ? '0 : clr_z_r + 1'b1;
          if (clr_z_r == CLR_MAX) clr_done_r <= 1'b1;
        end
      end
    end
  end

  // voxel memory
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r;
  logic          rd_in_r;
  logic [AW-1:0] addr_r;
  logic [31:0]   word;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign word = rd_in_r ? rdata_r : 32'd0;

  always_comb begin
    mem_we    = cmd.clr_step || (cmd.wr_en && rd_in_r);
    mem_waddr = cmd.clr_step ? clr_addr : addr_r;
    priority case (1'b1)
      cmd.clr_step:          mem_wdata = {31'd0, clr_floor};
      op_r == OP_WRITE_ID:   mem_wdata = {word[31:16], nid_r};
      op_r == OP_WRITE_META: mem_wdata = {nmeta_r, word[15:0]};
      default:               mem_wdata = {nmeta_r, nid_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_center || cmd.rd_nb) rdata_r <= mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_center || cmd.rd_nb) begin
      rd_in_r <= q_in;
      addr_r  <= q_addr;
    end
  end

  // face scan
  always_ff @(posedge clk) begin
    if (cmd.mask_cap) mask_r[face_r] <= (word[15:0] == 16'd0);
    if (cmd.face_clr) begin
      face_r   <= '0;
      corner_r <= '0;
    end else begin
      if (cmd.face_inc) face_r <= face_r + 3'd1;
      if (cmd.corner_inc) corner_r <= corner_r + 2'd1;
    end
  end

  logic [5:0] above_mask;
  logic       rest_empty;
  logic       vtx_last;

  assign above_mask = ~((6'd2 << face_r) - 6'd1);
  assign rest_empty = (mask_r & above_mask) == 6'd0;
  assign vtx_last   = (corner_r == 2'd3) && ((face_r == FACE_LAST) || rest_empty);

  // vertex counter
  logic [19:0] vcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
    end else if (cmd.vcnt_clr) begin
      vcnt_r <= '0;
    end else if (cmd.load_vtx) begin
      vcnt_r <= vcnt_r + 20'd1;
    end
  end

  // result register
  logic        out_valid_r;
  logic        out_free;
  logic [2:0]  corner;
  logic [15:0] o_id_r, o_meta_r;
  logic [5:0]  o_x_r, o_y_r, o_z_r;
  logic        o_u_r, o_v_r, o_last_r;
  logic [2:0]  o_dir_r;
  logic [19:0] o_num_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign corner   = CORNER_POS[FACE_CORNERS[face_r][corner_r]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_rd || cmd.load_vtx) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      o_id_r   <= word[15:0];
      o_meta_r <= word[31:16];
      o_x_r    <= '0;
      o_y_r    <= '0;
      o_z_r    <= '0;
      o_u_r    <= 1'b0;
      o_v_r    <= 1'b0;
      o_dir_r  <= '0;
      o_num_r  <= '0;
      o_last_r <= 1'b1;
    end else if (cmd.load_vtx) begin
      o_id_r   <= '0;
      o_meta_r <= '0;
      o_x_r    <= px_r[5:0] + {5'd0, corner[2]};
      o_y_r    <= py_r[5:0] + {5'd0, corner[1]};
      o_z_r    <= pz_r[5:0] + {5'd0, corner[0]};
      o_u_r    <= corner_r[0] ^ corner_r[1];
      o_v_r    <= corner_r[1];
      o_dir_r  <= face_r;
      o_num_r  <= vcnt_r;
      o_last_r <= vtx_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_id       = o_id_r;
  assign out_ch.read_meta     = o_meta_r;
  assign out_ch.vert_x        = o_x_r;
  assign out_ch.vert_y        = o_y_r;
  assign out_ch.vert_z        = o_z_r;
  assign out_ch.tex_u         = o_u_r;
  assign out_ch.tex_v         = o_v_r;
  assign out_ch.face_dir      = o_dir_r;
  assign out_ch.vertex_number = o_num_r;
  assign out_ch.last          = o_last_r;

  always_comb begin
    sts             = '0;
    sts.clear_done  = clr_done_r;
    sts.in_fire     = in_fire;
    sts.opcode      = op_r;
    sts.ctr_id_nz   = word[15:0] != 16'd0;
    sts.face_hit    = mask_r[face_r];
    sts.face_last   = face_r == FACE_LAST;
    sts.corner_last = corner_r == 2'd3;
    sts.rest_empty  = rest_empty;
    sts.out_free    = out_free;
  end

`ifndef SYNTH
  a_vcnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_vtx && !cmd.vcnt_clr |=> vcnt_r == $past(vcnt_r) + 20'd1)
    else $error("vertex counter did not advance on a vertex beat");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_rd || cmd.load_vtx) |-> out_free)
    else $error("result register overwritten while held");

  a_no_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !cmd.in_ready && !cmd.wr_en)
    else $error("command taken during store clear");
`endif

endmodule
